/* rtl/core/bpsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsc_pkg
// Shared types, constants and the microcode store of the battery power
// sample check.
// ----------------------------------------------------------------------------
package bpsc_pkg;

    // field widths
    localparam int TS_W     = 64;
    localparam int PIN_W    = 16;
    localparam int SEQ_W    = 32;
    localparam int STATUS_W = 3;
    localparam int MV_W     = 20;
    localparam int MA_W     = 20;
    localparam int RATIO_W  = 17;
    localparam int QUO_W    = 16;
    localparam int CFG_W    = 40;
    localparam int IDX_W    = 3;
    localparam int VGAIN_W  = 24;
    localparam int CGAIN_W  = 24;
    localparam int OFFS_W   = 16;
    localparam int WIN_W    = 40;

    // multiplier operands and product
    localparam int MUL_A_W  = PIN_W + 1;
    localparam int MUL_B_W  = VGAIN_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int FRAC_W   = 16;
    localparam int SCALED_W = PROD_W - FRAC_W;

    // register indexes
    localparam logic [IDX_W-1:0] REG_VOLTAGE_GAIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_CURRENT_OFFSET = 3'd1;
    localparam logic [IDX_W-1:0] REG_CURRENT_GAIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_VOLTAGE_WINDOW = 3'd3;
    localparam logic [IDX_W-1:0] REG_CURRENT_WINDOW = 3'd4;
    localparam logic [IDX_W-1:0] REG_EMPTY_LEVEL    = 3'd5;
    localparam logic [IDX_W-1:0] REG_FULL_LEVEL     = 3'd6;

    // register reset values
    localparam logic [VGAIN_W-1:0] VOLTAGE_GAIN_RST   = 24'd65536;
    localparam logic [CGAIN_W-1:0] CURRENT_GAIN_RST   = 24'd65536;
    localparam logic [WIN_W-1:0]   VOLTAGE_WINDOW_RST = 40'hFFFFF_00000;
    localparam logic [WIN_W-1:0]   CURRENT_WINDOW_RST = 40'h80000_80000;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TIME    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_DATA     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_VOLTAGE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CURRENT = 3'd4;

    // saturation bounds and full charge
    localparam logic [MV_W-1:0]        MV_MAX      = 20'hFFFFF;
    localparam logic signed [MA_W-1:0] MA_MAX      = 20'sh7FFFF;
    localparam logic signed [MA_W-1:0] MA_MIN      = 20'sh80000;
    localparam logic [RATIO_W-1:0]     RATIO_FULL  = 17'h10000;
    localparam logic [PROD_W-1:0]      ROUND_HALF  = 42'd32768;

    typedef struct packed {
        logic [VGAIN_W-1:0] voltage_gain;
        logic [OFFS_W-1:0]  current_zero_offset;
        logic [CGAIN_W-1:0] current_gain;
        logic [WIN_W-1:0]   voltage_window;
        logic [WIN_W-1:0]   current_window;
        logic [MV_W-1:0]    empty_level;
        logic [MV_W-1:0]    full_level;
    } cfg_t;

    typedef struct packed {
        logic [TS_W-1:0]  timestamp_us;
        logic             voltage_read_ok;
        logic [PIN_W-1:0] voltage_pin_mv;
        logic             current_read_ok;
        logic [PIN_W-1:0] current_pin_mv;
    } sample_t;

    // micro-operations of the datapath
    typedef enum logic [3:0] {
        UOP_NOP   = 4'd0,
        UOP_CHK   = 4'd1,
        UOP_MUL_V = 4'd2,
        UOP_BUS   = 4'd3,
        UOP_MUL_C = 4'd4,
        UOP_CUR   = 4'd5,
        UOP_WIN   = 4'd6,
        UOP_RANGE = 4'd7,
        UOP_DIV   = 4'd8,
        UOP_OUT   = 4'd9
    } uop_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NONE       = 3'd0,
        COND_ALWAYS     = 3'd1,
        COND_EARLY_FAIL = 3'd2,
        COND_WIN_FAIL   = 3'd3,
        COND_RATIO_EDGE = 3'd4,
        COND_DIV_MORE   = 3'd5,
        COND_OUT_BUSY   = 3'd6
    } cond_t;

    localparam int STEP_W = 4;

    // program steps
    localparam logic [STEP_W-1:0] STEP_CHK   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_V = 4'd1;
    localparam logic [STEP_W-1:0] STEP_BUS   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MUL_C = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CUR   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_WIN   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_RANGE = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DIV   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_OUT   = 4'd8;

    typedef struct packed {
        uop_t              op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic early_fail;
        logic win_fail;
        logic ratio_edge;
        logic div_more;
    } flags_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [MV_W-1:0]       bus_voltage_mv;
        logic signed [MA_W-1:0] battery_current_ma;
        logic [RATIO_W-1:0]    charge_ratio;
    } result_t;

    // microcode store: one control word per step
    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{op: UOP_NOP, cond: COND_ALWAYS, target: STEP_OUT};
        unique case (step)
            STEP_CHK:   w = '{op: UOP_CHK,   cond: COND_EARLY_FAIL, target: STEP_OUT};
            STEP_MUL_V: w = '{op: UOP_MUL_V, cond: COND_NONE,       target: STEP_CHK};
            STEP_BUS:   w = '{op: UOP_BUS,   cond: COND_NONE,       target: STEP_CHK};
            STEP_MUL_C: w = '{op: UOP_MUL_C, cond: COND_NONE,       target: STEP_CHK};
            STEP_CUR:   w = '{op: UOP_CUR,   cond: COND_NONE,       target: STEP_CHK};
            STEP_WIN:   w = '{op: UOP_WIN,   cond: COND_WIN_FAIL,   target: STEP_OUT};
            STEP_RANGE: w = '{op: UOP_RANGE, cond: COND_RATIO_EDGE, target: STEP_OUT};
            STEP_DIV:   w = '{op: UOP_DIV,   cond: COND_DIV_MORE,   target: STEP_DIV};
            STEP_OUT:   w = '{op: UOP_OUT,   cond: COND_OUT_BUSY,   target: STEP_OUT};
            default:    w = '{op: UOP_NOP,   cond: COND_ALWAYS,     target: STEP_OUT};
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/bpsc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsc_datapath
// Working registers, shared multiplier, window checks and the restoring
// divider, driven one control word per cycle.
// ----------------------------------------------------------------------------
module bpsc_datapath
(
    input  logic              clk,
    input  bpsc_pkg::uop_t    op,
    input  bpsc_pkg::cfg_t    cfg,
    input  bpsc_pkg::sample_t sample,
    output bpsc_pkg::flags_t  flags,
    output bpsc_pkg::result_t result
);

    logic [bpsc_pkg::STATUS_W-1:0]       status_reg;
    logic [bpsc_pkg::MV_W-1:0]           bus_reg;
    logic signed [bpsc_pkg::MA_W-1:0]    cur_reg;
    logic [bpsc_pkg::RATIO_W-1:0]        ratio_reg;
    logic signed [bpsc_pkg::MUL_A_W-1:0] diff_reg;
    logic signed [bpsc_pkg::PROD_W-1:0]  prod_reg;
    logic [bpsc_pkg::MV_W-1:0]           span_reg;
    logic [bpsc_pkg::MV_W-1:0]           rem_reg;
    logic [bpsc_pkg::QUO_W-1:0]          quo_reg;
    logic [3:0]                          cnt_reg;

    logic signed [bpsc_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [bpsc_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [bpsc_pkg::PROD_W-1:0]   mul_p;
    logic signed [bpsc_pkg::PROD_W-1:0]   rounded;
    logic signed [bpsc_pkg::SCALED_W-1:0] scaled;
    logic [bpsc_pkg::MV_W-1:0]            bus_sat;
    logic signed [bpsc_pkg::MA_W-1:0]     cur_sat;
    logic                                 ts_zero;
    logic                                 read_fail;
    logic                                 v_fail;
    logic                                 c_fail;
    logic                                 span_pos;
    logic [bpsc_pkg::MV_W:0]              rem_sh;
    logic                                 rem_ge;
    logic [bpsc_pkg::MV_W-1:0]            rem_next;
    logic [bpsc_pkg::QUO_W-1:0]           quo_next;

    // shared multiplier: voltage operands are zero-extended
    always_comb
    begin
        if (op == bpsc_pkg::UOP_MUL_V)
        begin
            mul_a = $signed({1'b0, sample.voltage_pin_mv});
            mul_b = $signed({1'b0, cfg.voltage_gain});
        end
        else
        begin
            mul_a = diff_reg;
            mul_b = $signed({cfg.current_gain[bpsc_pkg::CGAIN_W-1], cfg.current_gain});
        end
        mul_p = mul_a * mul_b;
    end

    // round half up and saturate
    always_comb
    begin
        rounded = prod_reg + $signed(bpsc_pkg::ROUND_HALF);
        scaled  = rounded[bpsc_pkg::PROD_W-1:bpsc_pkg::FRAC_W];
        if (scaled[bpsc_pkg::SCALED_W-1:bpsc_pkg::MV_W] != '0)
            bus_sat = bpsc_pkg::MV_MAX;
        else
            bus_sat = scaled[bpsc_pkg::MV_W-1:0];
        if (scaled > $signed({{(bpsc_pkg::SCALED_W-bpsc_pkg::MA_W){1'b0}}, bpsc_pkg::MA_MAX}))
            cur_sat = bpsc_pkg::MA_MAX;
        else if (scaled < $signed({{(bpsc_pkg::SCALED_W-bpsc_pkg::MA_W){1'b1}},
                                   bpsc_pkg::MA_MIN}))
            cur_sat = bpsc_pkg::MA_MIN;
        else
            cur_sat = scaled[bpsc_pkg::MA_W-1:0];
    end

    // status checks
    always_comb
    begin
        ts_zero   = (sample.timestamp_us == '0);
        read_fail = !sample.voltage_read_ok || !sample.current_read_ok;
        v_fail    = (bus_reg < cfg.voltage_window[19:0]) ||
                    (bus_reg > cfg.voltage_window[39:20]);
        c_fail    = (cur_reg < $signed(cfg.current_window[19:0])) ||
                    (cur_reg > $signed(cfg.current_window[39:20]));
        span_pos  = (cfg.full_level > cfg.empty_level);
    end

    // one restoring division step
    always_comb
    begin
        rem_sh = {rem_reg, 1'b0};
        rem_ge = (rem_sh >= {1'b0, span_reg});
        if (rem_ge)
        begin
            rem_next = rem_sh[bpsc_pkg::MV_W-1:0] - span_reg;
            quo_next = {quo_reg[bpsc_pkg::QUO_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[bpsc_pkg::MV_W-1:0];
            quo_next = {quo_reg[bpsc_pkg::QUO_W-2:0], 1'b0};
        end
    end

    // flags for the sequencer
    always_comb
    begin
        flags.early_fail = ts_zero || read_fail;
        flags.win_fail   = v_fail || c_fail || !span_pos;
        flags.ratio_edge = (bus_reg <= cfg.empty_level) || (bus_reg >= cfg.full_level);
        flags.div_more   = (cnt_reg != 4'd15);
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (op)
            bpsc_pkg::UOP_CHK:
            begin
                bus_reg   <= '0;
                cur_reg   <= '0;
                ratio_reg <= '0;
                diff_reg  <= $signed({1'b0, sample.current_pin_mv}) -
                             $signed({1'b0, cfg.current_zero_offset});
                if (ts_zero)
                    status_reg <= bpsc_pkg::STATUS_BAD_TIME;
                else if (read_fail)
                    status_reg <= bpsc_pkg::STATUS_NO_DATA;
                else
                    status_reg <= bpsc_pkg::STATUS_OK;
            end
            bpsc_pkg::UOP_MUL_V, bpsc_pkg::UOP_MUL_C:
            begin
                prod_reg <= mul_p;
            end
            bpsc_pkg::UOP_BUS:
            begin
                bus_reg <= bus_sat;
            end
            bpsc_pkg::UOP_CUR:
            begin
                cur_reg <= cur_sat;
            end
            bpsc_pkg::UOP_WIN:
            begin
                if (v_fail)
                    status_reg <= bpsc_pkg::STATUS_BAD_VOLTAGE;
                else if (c_fail)
                    status_reg <= bpsc_pkg::STATUS_BAD_CURRENT;
                else
                    status_reg <= bpsc_pkg::STATUS_OK;
            end
            bpsc_pkg::UOP_RANGE:
            begin
                if (bus_reg >= cfg.full_level)
                    ratio_reg <= bpsc_pkg::RATIO_FULL;
                else
                    ratio_reg <= '0;
                span_reg <= cfg.full_level - cfg.empty_level;
                rem_reg  <= bus_reg - cfg.empty_level;
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            bpsc_pkg::UOP_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    ratio_reg <= {1'b0, quo_next};
            end
            default:
            begin
            end
        endcase
    end

    assign result.status             = status_reg;
    assign result.bus_voltage_mv     = bus_reg;
    assign result.battery_current_ma = cur_reg;
    assign result.charge_ratio       = ratio_reg;

endmodule

/* rtl/core/battery_power_sample_check.sv */
`timescale 1ns / 1ps
// The microprogram jumps to the output step for a zero timestamp or a failed
// read, for a window failure or a non-positive charge span, and when the
// voltage is at or beyond a charge level; otherwise the 16-step divider runs.
// The next sample is taken the cycle after the result is registered. Reset
// restores the register defaults and clears the sample counter and all
// handshake state.
// ----------------------------------------------------------------------------
// battery_power_sample_check
// Microcoded checker that scales one ADC sample pair, tests it against the
// configured windows and computes the remaining charge ratio.
// ----------------------------------------------------------------------------
module battery_power_sample_check
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_write,
    input  logic [bpsc_pkg::IDX_W-1:0]            cfg_index,
    input  logic [bpsc_pkg::CFG_W-1:0]            cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [bpsc_pkg::TS_W-1:0]             timestamp_us,
    input  logic                                  voltage_read_ok,
    input  logic [bpsc_pkg::PIN_W-1:0]            voltage_pin_mv,
    input  logic                                  current_read_ok,
    input  logic [bpsc_pkg::PIN_W-1:0]            current_pin_mv,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bpsc_pkg::TS_W-1:0]             sample_time,
    output logic [bpsc_pkg::SEQ_W-1:0]            sequence_number,
    output logic [bpsc_pkg::STATUS_W-1:0]         status,
    output logic                                  valid_res,
    output logic [bpsc_pkg::MV_W-1:0]             bus_voltage_mv,
    output logic signed [bpsc_pkg::MA_W-1:0]      battery_current_ma,
    output logic [bpsc_pkg::RATIO_W-1:0]          charge_ratio
);

    bpsc_pkg::cfg_t               cfg_reg;
    bpsc_pkg::sample_t            sample_reg;
    logic [bpsc_pkg::SEQ_W-1:0]   counter_reg;
    logic [bpsc_pkg::SEQ_W-1:0]   seq_reg;
    logic                         busy_reg;
    logic [bpsc_pkg::STEP_W-1:0]  step_reg;
    logic [bpsc_pkg::STEP_W-1:0]  step_next;
    logic                         out_valid_reg;

    logic [bpsc_pkg::TS_W-1:0]     out_time_reg;
    logic [bpsc_pkg::SEQ_W-1:0]    out_seq_reg;
    bpsc_pkg::result_t             out_res_reg;

    bpsc_pkg::ctrl_t   ctrl;
    bpsc_pkg::uop_t    op;
    bpsc_pkg::flags_t  flags;
    bpsc_pkg::result_t result;
    logic              out_free;
    logic              jump;
    logic              accept;
    logic              finish;

    // configuration writes, out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voltage_gain        <= bpsc_pkg::VOLTAGE_GAIN_RST;
            cfg_reg.current_zero_offset <= '0;
            cfg_reg.current_gain        <= bpsc_pkg::CURRENT_GAIN_RST;
            cfg_reg.voltage_window      <= bpsc_pkg::VOLTAGE_WINDOW_RST;
            cfg_reg.current_window      <= bpsc_pkg::CURRENT_WINDOW_RST;
            cfg_reg.empty_level         <= '0;
            cfg_reg.full_level          <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bpsc_pkg::REG_VOLTAGE_GAIN:
                    cfg_reg.voltage_gain <= cfg_data[bpsc_pkg::VGAIN_W-1:0];
                bpsc_pkg::REG_CURRENT_OFFSET:
                    cfg_reg.current_zero_offset <= cfg_data[bpsc_pkg::OFFS_W-1:0];
                bpsc_pkg::REG_CURRENT_GAIN:
                    cfg_reg.current_gain <= cfg_data[bpsc_pkg::CGAIN_W-1:0];
                bpsc_pkg::REG_VOLTAGE_WINDOW:
                    cfg_reg.voltage_window <= cfg_data[bpsc_pkg::WIN_W-1:0];
                bpsc_pkg::REG_CURRENT_WINDOW:
                    cfg_reg.current_window <= cfg_data[bpsc_pkg::WIN_W-1:0];
                bpsc_pkg::REG_EMPTY_LEVEL:
                    cfg_reg.empty_level <= cfg_data[bpsc_pkg::MV_W-1:0];
                bpsc_pkg::REG_FULL_LEVEL:
                    cfg_reg.full_level <= cfg_data[bpsc_pkg::MV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // control word fetch and jump decision
    always_comb
    begin
        ctrl     = bpsc_pkg::ucode_rom(step_reg);
        op       = busy_reg ? ctrl.op : bpsc_pkg::UOP_NOP;
        out_free = !out_valid_reg || out_ready;
        unique case (ctrl.cond)
            bpsc_pkg::COND_NONE:       jump = 1'b0;
            bpsc_pkg::COND_ALWAYS:     jump = 1'b1;
            bpsc_pkg::COND_EARLY_FAIL: jump = flags.early_fail;
            bpsc_pkg::COND_WIN_FAIL:   jump = flags.win_fail;
            bpsc_pkg::COND_RATIO_EDGE: jump = flags.ratio_edge;
            bpsc_pkg::COND_DIV_MORE:   jump = flags.div_more;
            bpsc_pkg::COND_OUT_BUSY:   jump = !out_free;
            default:                   jump = 1'b0;
        endcase
        step_next = jump ? ctrl.target : step_reg + 4'd1;
        accept    = in_valid && !busy_reg;
        finish    = busy_reg && (ctrl.op == bpsc_pkg::UOP_OUT) && out_free;
    end

    // sequencer and handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= bpsc_pkg::STEP_CHK;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg    <= 1'b1;
                step_reg    <= bpsc_pkg::STEP_CHK;
                counter_reg <= counter_reg + 32'd1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
                step_reg <= bpsc_pkg::STEP_CHK;
            end
            else if (busy_reg)
            begin
                step_reg <= step_next;
            end

            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // sample capture and output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg.timestamp_us    <= timestamp_us;
            sample_reg.voltage_read_ok <= voltage_read_ok;
            sample_reg.voltage_pin_mv  <= voltage_pin_mv;
            sample_reg.current_read_ok <= current_read_ok;
            sample_reg.current_pin_mv  <= current_pin_mv;
            seq_reg                    <= counter_reg;
        end
        if (finish)
        begin
            out_time_reg <= sample_reg.timestamp_us;
            out_seq_reg  <= seq_reg;
            out_res_reg  <= result;
        end
    end

    bpsc_datapath u_datapath
    (
        .clk    (clk),
        .op     (op),
        .cfg    (cfg_reg),
        .sample (sample_reg),
        .flags  (flags),
        .result (result)
    );

    assign in_ready           = !busy_reg;
    assign out_valid          = out_valid_reg;
    assign sample_time        = out_time_reg;
    assign sequence_number    = out_seq_reg;
    assign status             = out_res_reg.status;
    assign valid_res          = (out_res_reg.status == bpsc_pkg::STATUS_OK);
    assign bus_voltage_mv     = out_res_reg.bus_voltage_mv;
    assign battery_current_ma = out_res_reg.battery_current_ma;
    assign charge_ratio       = out_res_reg.charge_ratio;

endmodule
